[hw/rtl/abcp_pkg.sv]
`default_nettype none

package abcp_pkg;

    // Queue depth and the widths that follow from it.
    localparam int MAX_BUFFERS = 50;
    localparam int IDX_W       = $clog2(MAX_BUFFERS);
    localparam int CNT_W       = $clog2(MAX_BUFFERS + 1);
    localparam int CMP_W       = ((CNT_W > 6) ? CNT_W : 6) + 2;

    // Fixed field widths.
    localparam int OP_W     = 3;
    localparam int TIME_W   = 32;
    localparam int ACTIVE_W = 6;
    localparam int BYTES_W  = 16;
    localparam int RATE_W   = 16;
    localparam int TAG_W    = 16;
    localparam int DUR_W    = 12;
    localparam int ADJ_W    = 9;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_POLL   = 3'd0;
    localparam logic [OP_W-1:0] OP_QUEUE  = 3'd1;
    localparam logic [OP_W-1:0] OP_PAUSE  = 3'd2;
    localparam logic [OP_W-1:0] OP_RESUME = 3'd3;
    localparam logic [OP_W-1:0] OP_STOP   = 3'd4;

    localparam logic signed [RATE_W-1:0] RATE_ACCEPTED = 16'sd22050;

    // bytes*1000/22050 is worked as (bytes*20)/441 by reciprocal multiply.
    localparam int                 X_W           = 21;
    localparam int                 RCP441_W      = 24;
    localparam int                 RCP441_SHIFT  = 32;
    localparam logic [RCP441_W-1:0] RCP441       = 24'd9739154;
    localparam logic [8:0]         DIVISOR_441   = 9'd441;

    // Division of a 12-bit duration by ten.
    localparam int                 RCP10_W       = 13;
    localparam int                 RCP10_SHIFT   = 16;
    localparam logic [RCP10_W-1:0] RCP10         = 13'd6554;

    // Division of a short elapsed time (below 16384 ms) by fifty.
    localparam int                 ESMALL_W      = 14;
    localparam int                 RCP50_W       = 15;
    localparam int                 RCP50_SHIFT   = 20;
    localparam logic [RCP50_W-1:0] RCP50         = 15'd20972;

    // Completion handshake.
    typedef enum logic [1:0] {
        HS_IDLE = 2'd0,
        HS_COMP = 2'd1,
        HS_DEAD = 2'd2
    } t_hs;

    // Item sequencer.
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_EXEC,
        SEQ_QDIV,
        SEQ_QWR,
        SEQ_POP,
        SEQ_ADJ1,
        SEQ_ADJ2,
        SEQ_OUT
    } t_seq;

endpackage

`default_nettype wire

[hw/rtl/audio_buffer_completion_pacer.sv]
`default_nettype none

// Audio buffer completion pacer. Each item is one event (poll, queue buffer,
// pause, resume or stop) and gives exactly one result item. Items are handled
// one at a time by a small sequencer around two FIFO memories (tags and
// durations, one read port each with registered read data). Pause, resume,
// stop, a refused queue event and a poll that releases nothing go from the
// execute step straight to the output step; an accepted queue event passes
// through a reciprocal multiply, a correction and a memory write; a poll
// that releases a buffer passes through a memory read, then, while buffers
// remain, the drift correction of the next deadline over two steps. The
// next item is taken as soon as the result sits in the output register, even
// while it still waits to be taken. No clearing pass is needed after reset.
module audio_buffer_completion_pacer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [abcp_pkg::OP_W-1:0]    i_op,
    input  logic [abcp_pkg::TIME_W-1:0]  i_now_ms,
    input  logic [abcp_pkg::ACTIVE_W-1:0] i_active_streams,
    input  logic [abcp_pkg::BYTES_W-1:0] i_buffer_bytes,
    input  logic signed [abcp_pkg::RATE_W-1:0] i_sample_rate,
    input  logic [abcp_pkg::TAG_W-1:0]   i_source_tag,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_ready_res,
    output logic [abcp_pkg::TAG_W-1:0]   o_done_tag,
    output logic                         o_accepted,
    output logic [abcp_pkg::ACTIVE_W-1:0] o_queued_count
);
    import abcp_pkg::*;

    // Sequencer and persistent state.
    t_seq                     r_seq, n_seq;
    logic [CNT_W-1:0]         r_outstanding, n_outstanding;
    logic signed [CMP_W-1:0]  r_completions, n_completions;
    t_hs                      r_hs, n_hs;
    logic                     r_paused, n_paused;
    logic [TIME_W-1:0]        r_deadline, n_deadline;
    logic [TIME_W-1:0]        r_lqt, n_lqt;
    logic [TIME_W-1:0]        r_pause_start, n_pause_start;
    logic [IDX_W-1:0]         r_head, n_head;
    logic                     r_rel, n_rel;
    logic                     r_acc, n_acc;

    // Captured item and working registers.
    logic [OP_W-1:0]          r_op;
    logic [TIME_W-1:0]        r_now;
    logic [ACTIVE_W-1:0]      r_active;
    logic                     r_rate_ok;
    logic [TAG_W-1:0]         r_tag_in;
    logic [X_W-1:0]           r_x;
    logic [X_W+RCP441_W-1:0]  r_prod, n_prod;
    logic [DUR_W-1:0]         r_dur, n_dur;
    logic [TIME_W-1:0]        r_elapsed, n_elapsed;
    logic [ADJ_W-1:0]         r_max_adj, n_max_adj;
    logic                     r_pos, n_pos;
    logic                     r_cap, n_cap;
    logic [ESMALL_W-1:0]      r_esmall, n_esmall;

    // Output register.
    logic                     r_out_valid;
    logic                     r_ready_res;
    logic [TAG_W-1:0]         r_done_tag;
    logic                     r_accepted;
    logic [ACTIVE_W-1:0]      r_queued_count;

    // FIFO memories and their read data.
    logic [TAG_W-1:0]         tag_mem [MAX_BUFFERS];
    logic [DUR_W-1:0]         dur_mem [MAX_BUFFERS];
    logic [TAG_W-1:0]         r_tag_rd;
    logic [DUR_W-1:0]         r_dur_rd;

    // Handshake and sequencer control.
    logic                     s_accept;
    logic                     s_load;
    logic                     s_rd_en;
    logic                     s_wr_en;

    // Decision signals.
    logic                     s_poll_live;
    logic signed [CMP_W-1:0]  s_completed;
    logic signed [CMP_W-1:0]  s_comp_upd;
    t_hs                      s_hs;
    logic                     s_rel;
    logic                     s_q_ok;
    logic [IDX_W-1:0]         s_head_inc;
    logic [CNT_W:0]           s_wr_sum;
    logic [CNT_W:0]           s_wr_wrap;
    logic [IDX_W-1:0]         s_wr_slot;
    logic [DUR_W-1:0]         s_q_est;
    logic [X_W-1:0]           s_rem;
    logic [DUR_W+RCP10_W-1:0] s_div10;
    logic [ESMALL_W+RCP50_W-1:0] s_div50;
    logic [TIME_W-1:0]        s_cap_lim;
    logic [ADJ_W-1:0]         s_adj;
    logic [CNT_W+ACTIVE_W-1:0] s_count_ext;

    // Handshake outputs of the sequencer.
    always_comb begin
        o_in_ready = (r_seq == SEQ_IDLE);
        s_accept   = i_in_valid && o_in_ready;
        s_load     = (r_seq == SEQ_OUT) && (!r_out_valid || i_out_ready);
        s_rd_en    = (r_seq == SEQ_EXEC);
        s_wr_en    = (r_seq == SEQ_QWR);
    end

    // Poll handshake and queue admission, decided in the execute step.
    always_comb begin
        s_poll_live = (r_outstanding != '0) && !r_paused;
        s_completed = $signed({{(CMP_W-CNT_W){1'b0}}, r_outstanding})
                    - $signed({{(CMP_W-ACTIVE_W){1'b0}}, r_active});
        s_comp_upd  = (s_completed > r_completions) ? s_completed : r_completions;
        s_hs  = r_hs;
        s_rel = 1'b0;
        if (s_comp_upd > 0) begin
            if (s_hs == HS_IDLE) begin
                s_hs = HS_COMP;
            end else if (s_hs == HS_DEAD) begin
                s_hs  = HS_IDLE;
                s_rel = 1'b1;
            end
        end
        if (!s_rel && (r_now >= r_deadline)) begin
            if (s_hs == HS_IDLE) begin
                s_hs = HS_DEAD;
            end else if (s_hs == HS_COMP) begin
                s_hs  = HS_IDLE;
                s_rel = 1'b1;
            end
        end
        s_q_ok = r_rate_ok
              && ({{(TIME_W-ACTIVE_W){1'b0}}, r_active} < TIME_W'(MAX_BUFFERS))
              && (r_outstanding < CNT_W'(MAX_BUFFERS));
    end

    // FIFO slot arithmetic: head advance and tail write slot, both modulo the depth.
    always_comb begin
        s_head_inc = (r_head == IDX_W'(MAX_BUFFERS - 1)) ? '0 : r_head + 1'b1;
        s_wr_sum   = (CNT_W+1)'(r_head) + {1'b0, r_outstanding};
        s_wr_wrap  = (s_wr_sum >= (CNT_W+1)'(MAX_BUFFERS))
                   ? s_wr_sum - (CNT_W+1)'(MAX_BUFFERS) : s_wr_sum;
        s_wr_slot  = s_wr_wrap[IDX_W-1:0];
    end

    // Reciprocal divisions and the drift limit.
    always_comb begin
        s_q_est     = r_prod[RCP441_SHIFT +: DUR_W];
        s_rem       = r_x - (X_W'(s_q_est) * X_W'(DIVISOR_441));
        s_div10     = r_dur_rd * RCP10;
        s_cap_lim   = TIME_W'({r_max_adj, 5'b0}) + TIME_W'({r_max_adj, 4'b0})
                    + TIME_W'({r_max_adj, 1'b0});
        s_div50     = r_esmall * RCP50;
        s_adj       = r_cap ? r_max_adj : s_div50[RCP50_SHIFT +: ADJ_W];
        s_count_ext = {{ACTIVE_W{1'b0}}, r_outstanding};
    end

    // Next state of the sequencer.
    always_comb begin
        n_seq = r_seq;
        case (r_seq)
            SEQ_IDLE: begin
                if (s_accept) begin
                    n_seq = SEQ_EXEC;
                end
            end
            SEQ_EXEC: begin
                if (r_op == OP_POLL && s_poll_live && s_rel) begin
                    n_seq = SEQ_POP;
                end else if (r_op == OP_QUEUE && s_q_ok) begin
                    n_seq = SEQ_QDIV;
                end else begin
                    n_seq = SEQ_OUT;
                end
            end
            SEQ_QDIV: n_seq = SEQ_QWR;
            SEQ_QWR:  n_seq = SEQ_OUT;
            SEQ_POP: begin
                n_seq = (r_outstanding == '0) ? SEQ_OUT : SEQ_ADJ1;
            end
            SEQ_ADJ1: n_seq = SEQ_ADJ2;
            SEQ_ADJ2: n_seq = SEQ_OUT;
            SEQ_OUT: begin
                if (s_load) begin
                    n_seq = SEQ_IDLE;
                end
            end
            default: n_seq = SEQ_IDLE;
        endcase
    end

    // Datapath: read-modify-write of the pacing state, step by step.
    always_comb begin
        n_outstanding = r_outstanding;
        n_completions = r_completions;
        n_hs          = r_hs;
        n_paused      = r_paused;
        n_deadline    = r_deadline;
        n_lqt         = r_lqt;
        n_pause_start = r_pause_start;
        n_head        = r_head;
        n_rel         = r_rel;
        n_acc         = r_acc;
        n_prod        = r_prod;
        n_dur         = r_dur;
        n_elapsed     = r_elapsed;
        n_max_adj     = r_max_adj;
        n_pos         = r_pos;
        n_cap         = r_cap;
        n_esmall      = r_esmall;
        case (r_seq)
            SEQ_IDLE: begin
                if (s_accept) begin
                    n_rel = 1'b0;
                    n_acc = 1'b0;
                end
            end
            SEQ_EXEC: begin
                case (r_op)
                    OP_POLL: begin
                        if (s_poll_live) begin
                            n_hs = s_hs;
                            if (s_rel) begin
                                n_completions = s_comp_upd - $signed(CMP_W'(1));
                                n_outstanding = r_outstanding - 1'b1;
                                n_head        = s_head_inc;
                                n_rel         = 1'b1;
                            end else begin
                                n_completions = s_comp_upd;
                            end
                        end
                    end
                    OP_QUEUE: begin
                        n_prod = r_x * RCP441;
                    end
                    OP_PAUSE: begin
                        if (!r_paused) begin
                            n_paused      = 1'b1;
                            n_pause_start = r_now;
                        end
                    end
                    OP_RESUME: begin
                        if (r_outstanding != '0) begin
                            n_deadline = r_deadline + (r_now - r_pause_start);
                        end
                        n_paused = 1'b0;
                    end
                    OP_STOP: begin
                        n_outstanding = '0;
                        n_completions = '0;
                        n_hs          = HS_IDLE;
                        n_paused      = 1'b0;
                        n_deadline    = '0;
                        n_lqt         = '0;
                        n_pause_start = '0;
                        n_head        = '0;
                    end
                    default: begin
                    end
                endcase
            end
            SEQ_QDIV: begin
                // The estimate is the quotient or one short of it.
                n_dur = (s_rem >= X_W'(DIVISOR_441)) ? s_q_est + 1'b1 : s_q_est;
            end
            SEQ_QWR: begin
                if (r_outstanding == '0) begin
                    n_deadline = r_now + TIME_W'(r_dur);
                    n_lqt      = r_now;
                    if (r_paused) begin
                        n_pause_start = r_now;
                    end
                end
                n_outstanding = r_outstanding + 1'b1;
                n_acc         = 1'b1;
            end
            SEQ_POP: begin
                n_dur     = r_dur_rd;
                n_elapsed = r_deadline - r_lqt;
                n_max_adj = s_div10[RCP10_SHIFT +: ADJ_W];
            end
            SEQ_ADJ1: begin
                // Positive drift is a twos-complement test on the difference.
                n_pos    = !r_elapsed[TIME_W-1] && (r_elapsed != '0);
                n_cap    = (r_elapsed >= s_cap_lim);
                n_esmall = r_elapsed[ESMALL_W-1:0];
            end
            SEQ_ADJ2: begin
                if (r_pos) begin
                    n_deadline = r_deadline + (TIME_W'(r_dur) - TIME_W'(s_adj));
                end else begin
                    n_deadline = r_lqt + TIME_W'(r_dur);
                end
                n_lqt = r_now;
            end
            default: begin
            end
        endcase
    end

    // Control state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq         <= SEQ_IDLE;
            r_outstanding <= '0;
            r_completions <= '0;
            r_hs          <= HS_IDLE;
            r_paused      <= 1'b0;
            r_deadline    <= '0;
            r_lqt         <= '0;
            r_pause_start <= '0;
            r_head        <= '0;
            r_rel         <= 1'b0;
            r_acc         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_seq         <= n_seq;
            r_outstanding <= n_outstanding;
            r_completions <= n_completions;
            r_hs          <= n_hs;
            r_paused      <= n_paused;
            r_deadline    <= n_deadline;
            r_lqt         <= n_lqt;
            r_pause_start <= n_pause_start;
            r_head        <= n_head;
            r_rel         <= n_rel;
            r_acc         <= n_acc;
            if (s_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item capture, working registers and the output payload.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op      <= i_op;
            r_now     <= i_now_ms;
            r_active  <= i_active_streams;
            r_rate_ok <= (i_sample_rate == RATE_ACCEPTED);
            r_tag_in  <= i_source_tag;
            r_x       <= X_W'({i_buffer_bytes, 4'b0}) + X_W'({i_buffer_bytes, 2'b0});
        end
        r_prod    <= n_prod;
        r_dur     <= n_dur;
        r_elapsed <= n_elapsed;
        r_max_adj <= n_max_adj;
        r_pos     <= n_pos;
        r_cap     <= n_cap;
        r_esmall  <= n_esmall;
        if (s_load) begin
            r_ready_res    <= r_rel;
            r_done_tag     <= r_rel ? r_tag_rd : '0;
            r_accepted     <= r_acc;
            r_queued_count <= s_count_ext[ACTIVE_W-1:0];
        end
    end

    // FIFO memories: the tail write and the head reads never meet in one
    // cycle, as the sequencer handles one item at a time.
    always_ff @(posedge i_clk) begin
        if (s_wr_en) begin
            tag_mem[s_wr_slot] <= r_tag_in;
            dur_mem[s_wr_slot] <= r_dur;
        end
        if (s_rd_en) begin
            r_tag_rd <= tag_mem[r_head];
            r_dur_rd <= dur_mem[s_head_inc];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_ready_res    = r_ready_res;
    assign o_done_tag     = r_done_tag;
    assign o_accepted     = r_accepted;
    assign o_queued_count = r_queued_count;

endmodule

`default_nettype wire

[hw/rtl/abcp_checker.sv]
`default_nettype none

module abcp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic                          o_ready_res,
    input logic [abcp_pkg::TAG_W-1:0]    o_done_tag,
    input logic                          o_accepted,
    input logic [abcp_pkg::ACTIVE_W-1:0] o_queued_count
);
    import abcp_pkg::*;

    // A result never both releases a buffer and accepts one.
    a_release_xor_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_ready_res && o_accepted))
        else $error("result both releases and accepts a buffer");

    // The tag is zero whenever no buffer is released.
    a_tag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ready_res) |-> (o_done_tag == '0))
        else $error("tag shown without a release");

    // Items are taken one at a time: the input closes after each item.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken while one is in work");

    // The outstanding count never exceeds the queue depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_queued_count) <= MAX_BUFFERS))
        else $error("queued count beyond queue depth");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_done_tag)))
        else $error("stalled result dropped or changed");

endmodule

bind audio_buffer_completion_pacer abcp_checker u_abcp_checker (.*);

`default_nettype wire
